// ===== rtl/core/qto_pkg.sv =====
// Package for the quaternion tool offset unit: shared types and pipeline constants.
// Has no dependencies; every other file in rtl/core but qto_checker imports it.
package qto_pkg;

  // Latency of the front end (quaternion products, then the numerators and the norm).
  localparam int unsigned FrontLat   = 2;
  // The divider retires this many quotient bits per register stage.
  localparam int unsigned DivBits    = 2;
  localparam int unsigned QuoWidth   = 32;
  localparam int unsigned DivStages  = QuoWidth / DivBits;
  // One multiply stage and one dividend stage come before the divider.
  localparam int unsigned LaneLat    = 2 + DivStages;
  localparam int unsigned Latency    = FrontLat + LaneLat + 1;

  // Operands of one axis: magnitudes of the numerator and the tool length, the sign
  // of their product, and the squared norm of the quaternion.
  typedef struct packed {
    logic [32:0] mag_n;
    logic [31:0] mag_l;
    logic        neg;
    logic [32:0] norm;
  } lane_in_t;

  // Fields that travel beside the arithmetic up to the output stage.
  typedef struct packed {
    logic        action;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic        degen;
  } side_t;

endpackage

// ===== rtl/core/qto_front.sv =====
// Front end of the quaternion tool offset unit: component products, axis numerators, norm.
// Depends on qto_pkg.
module qto_front (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              action_i,
  input  logic [31:0]       pos_x_i,
  input  logic [31:0]       pos_y_i,
  input  logic [31:0]       pos_z_i,
  input  logic [15:0]       quat_w_i,
  input  logic [15:0]       quat_x_i,
  input  logic [15:0]       quat_y_i,
  input  logic [15:0]       quat_z_i,
  input  logic [31:0]       tool_length_i,
  output qto_pkg::lane_in_t lane_o [3],
  output qto_pkg::side_t    side_o
);
  import qto_pkg::*;

  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xz_q, yw_q, yz_q, xw_q;
  side_t              side1_q, side2_q;
  side_t              side_d;
  lane_in_t           lane_q [3];
  lane_in_t           lane_d [3];
  logic               degen_d;

  // First stage: the eight 16 by 16 products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ww_q <= $signed(quat_w_i) * $signed(quat_w_i);
      xx_q <= $signed(quat_x_i) * $signed(quat_x_i);
      yy_q <= $signed(quat_y_i) * $signed(quat_y_i);
      zz_q <= $signed(quat_z_i) * $signed(quat_z_i);
      xz_q <= $signed(quat_x_i) * $signed(quat_z_i);
      yw_q <= $signed(quat_y_i) * $signed(quat_w_i);
      yz_q <= $signed(quat_y_i) * $signed(quat_z_i);
      xw_q <= $signed(quat_x_i) * $signed(quat_w_i);
      side1_q <= '{action: action_i, pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
                   qw: quat_w_i, qx: quat_x_i, qy: quat_y_i, qz: quat_z_i, degen: 1'b0};
    end
  end

  // Second stage: norm, the three numerators and their magnitudes.
  always_comb begin
    logic        [32:0] norm;
    logic signed [33:0] n0, n1, n2;
    logic        [31:0] mag_l;
    logic               len_neg;
    norm = {1'b0, ww_q} + {1'b0, xx_q} + {1'b0, yy_q} + {1'b0, zz_q};
    n0 = ({{2{xz_q[31]}}, xz_q} + {{2{yw_q[31]}}, yw_q}) <<< 1;
    n1 = ({{2{yz_q[31]}}, yz_q} - {{2{xw_q[31]}}, xw_q}) <<< 1;
    n2 = {2'b00, ww_q} + {2'b00, zz_q} - {2'b00, xx_q} - {2'b00, yy_q};
    len_neg = tool_length_i[31];
    mag_l = len_neg ? (32'd0 - tool_length_i) : tool_length_i;
    degen_d = (norm == 33'd0);
    lane_d[0] = '{mag_n: n0[33] ? 33'(-n0) : n0[32:0], mag_l: mag_l,
                  neg: n0[33] ^ len_neg, norm: norm};
    lane_d[1] = '{mag_n: n1[33] ? 33'(-n1) : n1[32:0], mag_l: mag_l,
                  neg: n1[33] ^ len_neg, norm: norm};
    lane_d[2] = '{mag_n: n2[33] ? 33'(-n2) : n2[32:0], mag_l: mag_l,
                  neg: n2[33] ^ len_neg, norm: norm};
    side_d = side1_q;
    side_d.degen = degen_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
      side2_q <= side_d;
    end
  end

  assign lane_o = lane_q;
  assign side_o = side2_q;

endmodule

// ===== rtl/core/qto_lane.sv =====
// One axis of the quaternion tool offset unit: split multiply, then a pipelined divider
// that forms the rounded quotient of numerator times tool length over the norm. Uses qto_pkg.
module qto_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  qto_pkg::lane_in_t lane_i,
  output logic [31:0]       quo_o,
  output logic              neg_o
);
  import qto_pkg::*;

  logic [48:0] pp_lo_q, pp_hi_q;
  logic [32:0] norm_c_q;
  logic        neg_c_q;
  logic [64:0] dvd_d;

  logic [32:0] rem_q  [DivStages+1];
  logic [31:0] low_q  [DivStages+1];
  logic [32:0] norm_q [DivStages+1];
  logic        neg_q  [DivStages+1];

  // The 33 by 32 product is taken as two 33 by 16 halves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_lo_q  <= lane_i.mag_n * lane_i.mag_l[15:0];
      pp_hi_q  <= lane_i.mag_n * lane_i.mag_l[31:16];
      norm_c_q <= lane_i.norm;
      neg_c_q  <= lane_i.neg;
    end
  end

  // Half the divisor is added so the truncating divide rounds ties away from zero.
  assign dvd_d = {pp_hi_q, 16'd0} + {16'd0, pp_lo_q} + {33'd0, norm_c_q[32:1]};

  // The upper half of the dividend is already below the divisor, since the quotient
  // never exceeds the tool length magnitude.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= dvd_d[64:32];
      low_q[0]  <= dvd_d[31:0];
      norm_q[0] <= norm_c_q;
      neg_q[0]  <= neg_c_q;
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [32:0] rem_d;
    logic [31:0] low_d;

    always_comb begin
      logic [33:0] trial;
      rem_d = rem_q[k];
      low_d = low_q[k];
      for (int j = 0; j < DivBits; j++) begin
        trial = {rem_d, low_d[31]} - {1'b0, norm_q[k]};
        if (!trial[33]) begin
          rem_d = trial[32:0];
        end else begin
          rem_d = {rem_d[31:0], low_d[31]};
        end
        low_d = {low_d[30:0], ~trial[33]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        low_q[k+1]  <= low_d;
        norm_q[k+1] <= norm_q[k];
        neg_q[k+1]  <= neg_q[k];
      end
    end
  end

  assign quo_o = low_q[DivStages];
  assign neg_o = neg_q[DivStages];

endmodule

// ===== rtl/core/qto_apply.sv =====
// Output stage of the quaternion tool offset unit: signs the offsets, adds or subtracts
// them and clips to the position range, or passes the position of a degenerate pose. Uses qto_pkg.
module qto_apply (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [31:0]    quo_i [3],
  input  logic           neg_i [3],
  input  qto_pkg::side_t side_i,
  output logic [31:0]    out_x_o,
  output logic [31:0]    out_y_o,
  output logic [31:0]    out_z_o,
  output logic [15:0]    out_w_o,
  output logic [15:0]    out_qx_o,
  output logic [15:0]    out_qy_o,
  output logic [15:0]    out_qz_o,
  output logic           degenerate_o,
  output logic           saturated_o
);
  import qto_pkg::*;

  logic [31:0] pos [3];
  logic [31:0] res_d [3];
  logic        sat_d;
  logic [31:0] res_q [3];
  logic        sat_q;
  side_t       side_q;

  assign pos[0] = side_i.pos_x;
  assign pos[1] = side_i.pos_y;
  assign pos[2] = side_i.pos_z;

  always_comb begin
    logic [33:0] off;
    logic [34:0] sum;
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      off = neg_i[i] ? (34'd0 - {2'b00, quo_i[i]}) : {2'b00, quo_i[i]};
      if (side_i.action) begin
        sum = {{3{pos[i][31]}}, pos[i]} + {off[33], off};
      end else begin
        sum = {{3{pos[i][31]}}, pos[i]} - {off[33], off};
      end
      if (side_i.degen) begin
        res_d[i] = pos[i];
      end else if (sum[34:31] != 4'b0000 && sum[34:31] != 4'b1111) begin
        res_d[i] = sum[34] ? 32'h8000_0000 : 32'h7fff_ffff;
        sat_d = 1'b1;
      end else begin
        res_d[i] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q  <= res_d;
      sat_q  <= sat_d;
      side_q <= side_i;
    end
  end

  assign out_x_o      = res_q[0];
  assign out_y_o      = res_q[1];
  assign out_z_o      = res_q[2];
  assign out_w_o      = side_q.qw;
  assign out_qx_o     = side_q.qx;
  assign out_qy_o     = side_q.qy;
  assign out_qz_o     = side_q.qz;
  assign degenerate_o = side_q.degen;
  assign saturated_o  = sat_q;

endmodule

// ===== rtl/core/quaternion_tool_offset_unit.sv =====
// Top level of the quaternion tool offset unit: configuration register, valid pipeline,
// and the front end, three axis lanes and output stage. Depends on qto_pkg and its modules.
//
// Each input word carries a pose (Q16.16 position, Q2.14 quaternion) and an action bit.
// The block moves the position along the tool z axis, the third column of the rotation
// of the normalized quaternion, by the configured tool length: subtracted for action 0,
// added for action 1. The quaternion passes through. Sums are clipped to the 32-bit
// range and flagged; an all-zero quaternion passes the position and sets degenerate.
// Both channels use valid and stall; a word moves when valid is high and stall is low.
// One word is accepted every cycle unless stall_o is high. The pipeline has two front-end
// stages, one multiply stage, one dividend stage, sixteen divider stages at two quotient
// bits each, and the output register. The divider chain sets the depth.
// When the receiver stalls a waiting result, the whole pipeline holds and stall_o is
// raised toward the sender, so nothing is lost or repeated; bubbles are never taken.
// Reset clears all valid bits and sets tool_length to zero. The user must write the tool
// length through cfg_we_i and cfg_wdata_i only while no word is in flight (not enforced).
module quaternion_tool_offset_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        action_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic [15:0] quat_w_i,
  input  logic [15:0] quat_x_i,
  input  logic [15:0] quat_y_i,
  input  logic [15:0] quat_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [15:0] out_w_o,
  output logic [15:0] out_qx_o,
  output logic [15:0] out_qy_o,
  output logic [15:0] out_qz_o,
  output logic        degenerate_o,
  output logic        saturated_o
);
  import qto_pkg::*;

  logic        en;
  logic [31:0] tool_length_q;
  logic        vld_q [Latency];
  lane_in_t    lane_in [3];
  side_t       side_front;
  side_t       side_q [LaneLat];
  logic [31:0] quo [3];
  logic        neg [3];

  // The pipeline advances unless a finished result is held by the receiver.
  assign en      = ~(vld_q[Latency-1] & stall_i);
  assign stall_o = ~en;
  assign valid_o = vld_q[Latency-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tool_length_q <= '0;
    end else if (cfg_we_i) begin
      tool_length_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Latency; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < Latency; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  qto_front u_front (
    .clk_i,
    .en_i          (en),
    .action_i,
    .pos_x_i,
    .pos_y_i,
    .pos_z_i,
    .quat_w_i,
    .quat_x_i,
    .quat_y_i,
    .quat_z_i,
    .tool_length_i (tool_length_q),
    .lane_o        (lane_in),
    .side_o        (side_front)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    qto_lane u_lane (
      .clk_i,
      .en_i   (en),
      .lane_i (lane_in[a]),
      .quo_o  (quo[a]),
      .neg_o  (neg[a])
    );
  end

  // Pose and flags wait beside the lanes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_front;
      for (int i = 1; i < LaneLat; i++) side_q[i] <= side_q[i-1];
    end
  end

  qto_apply u_apply (
    .clk_i,
    .en_i   (en),
    .quo_i  (quo),
    .neg_i  (neg),
    .side_i (side_q[LaneLat-1]),
    .out_x_o,
    .out_y_o,
    .out_z_o,
    .out_w_o,
    .out_qx_o,
    .out_qy_o,
    .out_qz_o,
    .degenerate_o,
    .saturated_o
  );

endmodule

// ===== rtl/core/qto_checker.sv =====
// Port checker for the quaternion tool offset unit, bound to the top level.
// Sees only the top-level ports.
module qto_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] out_x_o,
  input logic [31:0] out_y_o,
  input logic [31:0] out_z_o,
  input logic [15:0] out_w_o,
  input logic [15:0] out_qx_o,
  input logic [15:0] out_qy_o,
  input logic [15:0] out_qz_o,
  input logic        degenerate_o,
  input logic        saturated_o
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> $stable(out_x_o) && $stable(out_y_o) && $stable(out_z_o)
                           && $stable(saturated_o))
    else $error("stalled result word changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> out_w_o == 16'd0 && out_qx_o == 16'd0
                                && out_qy_o == 16'd0 && out_qz_o == 16'd0 && !saturated_o)
    else $error("degenerate flag with nonzero quaternion or clipping");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && saturated_o |->
      out_x_o == 32'h7fff_ffff || out_x_o == 32'h8000_0000 ||
      out_y_o == 32'h7fff_ffff || out_y_o == 32'h8000_0000 ||
      out_z_o == 32'h7fff_ffff || out_z_o == 32'h8000_0000)
    else $error("saturated flag without a clipped coordinate");

endmodule

bind quaternion_tool_offset_unit qto_checker u_qto_checker (.*);

// ===== tb/tb_quaternion_tool_offset_unit.sv =====
`timescale 1ns / 1ps
// Testbench for quaternion_tool_offset_unit: drives random and directed poses, predicts each
// offset position and compares every result word. Depends on the RTL and on qto_pkg.
module tb_quaternion_tool_offset_unit;
  import qto_pkg::*;

  // Action codes of the input word.
  typedef enum logic {
    ActTipToBase = 1'b0,
    ActBaseToTip = 1'b1
  } offset_dir_e;

  localparam int unsigned CfgIndexToolLength = 0;
  localparam int unsigned IdleLimit = 2000;

  // One pose as the sender presents it.
  typedef struct packed {
    offset_dir_e action;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
  } pose_t;

  // One result word as the block returns it.
  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [15:0] qw;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic        degen;
    logic        sat;
  } offset_pose_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        valid_i;
  logic        stall_o;
  logic        action_i;
  logic [31:0] pos_x_i, pos_y_i, pos_z_i;
  logic [15:0] quat_w_i, quat_x_i, quat_y_i, quat_z_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic [15:0] out_w_o, out_qx_o, out_qy_o, out_qz_o;
  logic        degenerate_o;
  logic        saturated_o;

  quaternion_tool_offset_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .action_i     (action_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .quat_w_i     (quat_w_i),
    .quat_x_i     (quat_x_i),
    .quat_y_i     (quat_y_i),
    .quat_z_i     (quat_z_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_w_o      (out_w_o),
    .out_qx_o     (out_qx_o),
    .out_qy_o     (out_qy_o),
    .out_qz_o     (out_qz_o),
    .degenerate_o (degenerate_o),
    .saturated_o  (saturated_o)
  );

  // Local copy of the tool length register, and the results still owed by the block.
  logic signed [31:0] tool_len_q;
  offset_pose_t       owed_poses[$];
  int unsigned        fail_count;
  int unsigned        idle_cycles;
  bit                 sender_bursty;
  bit                 receiver_bursty;
  bit                 sent_one;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Rounds |n * len| / s to nearest with ties away from zero and applies the sign of the
  // product. The 33-bit numerator times the 32-bit length fits easily in 80 bits.
  function automatic logic signed [63:0] axis_offset(logic signed [63:0] n,
                                                      logic signed [63:0] len,
                                                      logic signed [63:0] s);
    logic               neg;
    logic [79:0]        mag;
    logic [79:0]        quo;
    neg = (n < 0) != (len < 0);
    mag = 80'((n < 0) ? -n : n) * 80'((len < 0) ? -len : len);
    quo = (mag + 80'(s / 2)) / 80'(s);
    return neg ? -64'(quo) : 64'(quo);
  endfunction

  // Works out the result word for one pose under the current tool length.
  function automatic offset_pose_t predict_offset(pose_t p);
    offset_pose_t       r;
    logic signed [63:0] w, x, y, z, s;
    logic signed [63:0] num[3];
    logic signed [63:0] pos[3];
    logic signed [63:0] sum;
    logic [31:0]        res[3];
    w = 64'(signed'(p.qw));
    x = 64'(signed'(p.qx));
    y = 64'(signed'(p.qy));
    z = 64'(signed'(p.qz));
    s = w * w + x * x + y * y + z * z;
    num[0] = 2 * (x * z + y * w);
    num[1] = 2 * (y * z - x * w);
    num[2] = w * w + z * z - x * x - y * y;
    pos[0] = 64'(signed'(p.px));
    pos[1] = 64'(signed'(p.py));
    pos[2] = 64'(signed'(p.pz));
    r = '0;
    r.degen = (s == 0);
    for (int i = 0; i < 3; i++) begin
      if (r.degen) begin
        res[i] = pos[i][31:0];
      end else begin
        sum = axis_offset(num[i], 64'(tool_len_q), s);
        sum = (p.action == ActBaseToTip) ? pos[i] + sum : pos[i] - sum;
        if (sum > 64'sd2147483647) begin
          res[i] = 32'h7fff_ffff;
          r.sat = 1'b1;
        end else if (sum < -64'sd2147483648) begin
          res[i] = 32'h8000_0000;
          r.sat = 1'b1;
        end else begin
          res[i] = sum[31:0];
        end
      end
    end
    r.ox = res[0];
    r.oy = res[1];
    r.oz = res[2];
    r.qw = p.qw;
    r.qx = p.qx;
    r.qy = p.qy;
    r.qz = p.qz;
    return r;
  endfunction

  // The receiver: stalls in random bursts while bursty, and checks each accepted word
  // against the oldest owed result. Stall changes at the falling edge only.
  initial begin
    int unsigned hold;
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_bursty && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 16);
        stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    offset_pose_t got, want;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{out_x_o, out_y_o, out_z_o, out_w_o, out_qx_o, out_qy_o, out_qz_o,
              degenerate_o, saturated_o};
      if (owed_poses.size() == 0) begin
        $error("result word with no expectation: out_x %h", got.ox);
        fail_count++;
      end else begin
        want = owed_poses.pop_front();
        if (got.ox !== want.ox) begin
          $error("out_x expected %h actual %h", want.ox, got.ox);
          fail_count++;
        end
        if (got.oy !== want.oy) begin
          $error("out_y expected %h actual %h", want.oy, got.oy);
          fail_count++;
        end
        if (got.oz !== want.oz) begin
          $error("out_z expected %h actual %h", want.oz, got.oz);
          fail_count++;
        end
        if (got.qw !== want.qw) begin
          $error("out_w expected %h actual %h", want.qw, got.qw);
          fail_count++;
        end
        if (got.qx !== want.qx) begin
          $error("out_qx expected %h actual %h", want.qx, got.qx);
          fail_count++;
        end
        if (got.qy !== want.qy) begin
          $error("out_qy expected %h actual %h", want.qy, got.qy);
          fail_count++;
        end
        if (got.qz !== want.qz) begin
          $error("out_qz expected %h actual %h", want.qz, got.qz);
          fail_count++;
        end
        if (got.degen !== want.degen) begin
          $error("degenerate expected %b actual %b", want.degen, got.degen);
          fail_count++;
        end
        if (got.sat !== want.sat) begin
          $error("saturated expected %b actual %b", want.sat, got.sat);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves a word means a hang.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sends one pose: an optional random gap first, then valid held until accepted.
  // Back-to-back words keep valid high, so it is never lowered and raised in one step.
  task automatic send_pose(pose_t p);
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    valid_i  <= 1'b1;
    action_i <= p.action;
    pos_x_i  <= p.px;
    pos_y_i  <= p.py;
    pos_z_i  <= p.pz;
    quat_w_i <= p.qw;
    quat_x_i <= p.qx;
    quat_y_i <= p.qy;
    quat_z_i <= p.qz;
    owed_poses = {owed_poses, predict_offset(p)};
    do @(posedge clk_i); while (stall_o);
    @(negedge clk_i);
  endtask

  // Lets the pipeline drain, then writes the tool length while nothing is in flight.
  task automatic set_tool_length(logic [31:0] len);
    valid_i <= 1'b0;
    wait (owed_poses.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tool_len_q  = len;
  endtask

  function automatic pose_t random_pose();
    pose_t p;
    p.action = offset_dir_e'($urandom_range(0, 1));
    p.px = $urandom();
    p.py = $urandom();
    p.pz = $urandom();
    // Half the time quaternions in Q2.14 with components within +-0.5, else arbitrary or tiny ones.
    case ($urandom_range(0, 3))
      0: begin
        p.qw = $urandom();
        p.qx = $urandom();
        p.qy = $urandom();
        p.qz = $urandom();
      end
      1: begin
        p.qw = 16'($signed($urandom_range(0, 8)) - 4);
        p.qx = 16'($signed($urandom_range(0, 8)) - 4);
        p.qy = 16'($signed($urandom_range(0, 8)) - 4);
        p.qz = 16'($signed($urandom_range(0, 8)) - 4);
      end
      default: begin
        p.qw = 16'($signed($urandom_range(0, 16384)) - 8192);
        p.qx = 16'($signed($urandom_range(0, 16384)) - 8192);
        p.qy = 16'($signed($urandom_range(0, 16384)) - 8192);
        p.qz = 16'($signed($urandom_range(0, 16384)) - 8192);
      end
    endcase
    // Positions near the rails make clipping common.
    if ($urandom_range(0, 3) == 0) p.px = {~p.px[31], {31{p.px[31]}}} ^ 32'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) p.pz = {~p.pz[31], {31{p.pz[31]}}} ^ 32'($urandom_range(0, 255));
    return p;
  endfunction

  // Zero tool length: every offset is zero, whatever the orientation.
  task automatic test_zero_length();
    set_tool_length(32'h0);
    send_pose('{ActTipToBase, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h4000, 16'h0, 16'h0,
                16'h0});
    send_pose('{ActBaseToTip, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 16'h8000,
                16'h8000, 16'h8000, 16'h8000});
  endtask

  // Extremes of length, position and quaternion, both actions, the all-zero quaternion,
  // the identity and the half turns about each axis, and clipping at both rails.
  task automatic test_directed_poses();
    set_tool_length(32'h0001_0000);
    send_pose('{ActTipToBase, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0});
    send_pose('{ActBaseToTip, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h0});
    send_pose('{ActTipToBase, 32'h0, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0, 16'h0});
    send_pose('{ActBaseToTip, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h4000, 16'h0});
    send_pose('{ActBaseToTip, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000});
    send_pose('{ActBaseToTip, 32'h1, 32'h2, 32'h3, 16'h0, 16'h0, 16'h0, 16'h0});
    send_pose('{ActBaseToTip, 32'h3000, 32'h0, 32'h0, 16'h2d41, 16'h2d41, 16'h2d41,
                16'h2d41});
    set_tool_length(32'h7fff_ffff);
    send_pose('{ActBaseToTip, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h4000, 16'h0,
                16'h0, 16'h0});
    send_pose('{ActTipToBase, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h4000,
                16'h0, 16'h0, 16'h0});
    send_pose('{ActBaseToTip, 32'h0, 32'h0, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
    send_pose('{ActTipToBase, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h8000, 16'h8000,
                16'h7fff, 16'h8000});
    send_pose('{ActBaseToTip, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h0, 16'h0,
                16'h0, 16'h0});
    set_tool_length(32'h8000_0000);
    send_pose('{ActBaseToTip, 32'h8000_0000, 32'h0, 32'h8000_0000, 16'h4000, 16'h0, 16'h0,
                16'h0});
    send_pose('{ActTipToBase, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 16'h4000, 16'h0, 16'h0,
                16'h0});
    send_pose('{ActTipToBase, 32'h0, 32'h0, 32'h0, 16'h1, 16'h1, 16'hffff, 16'h1});
    // A tool length of three LSBs with tiny quaternions keeps the offsets within three LSBs.
    set_tool_length(32'h3);
    send_pose('{ActBaseToTip, 32'h0, 32'h0, 32'h0, 16'h1, 16'h0, 16'h0, 16'h1});
    send_pose('{ActTipToBase, 32'h0, 32'h0, 32'h0, 16'h1, 16'h1, 16'h0, 16'h0});
  endtask

  // Random poses over several tool lengths, with idling on both sides while the bursty flags are set.
  task automatic test_random_poses(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: set_tool_length($urandom());
          1: set_tool_length(32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh2_0000));
          2: set_tool_length($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
          default: set_tool_length(32'($urandom_range(0, 16)));
        endcase
      end
      send_pose(random_pose());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    valid_i     = 1'b0;
    action_i    = 1'b0;
    pos_x_i     = '0;
    pos_y_i     = '0;
    pos_z_i     = '0;
    quat_w_i    = '0;
    quat_x_i    = '0;
    quat_y_i    = '0;
    quat_z_i    = '0;
    tool_len_q  = '0;
    fail_count  = 0;
    idle_cycles = 0;
    sender_bursty   = 1'b1;
    receiver_bursty = 1'b1;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // The register index is fixed; it is named here for the one writable register.
    if (CfgIndexToolLength != 0) $error("unexpected register index");
    test_zero_length();
    test_directed_poses();
    test_random_poses(700);
    // The last part runs with no idling so the pipeline stays full.
    sender_bursty   = 1'b0;
    receiver_bursty = 1'b0;
    test_random_poses(150);

    valid_i <= 1'b0;
    wait (owed_poses.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/qto_pkg.sv
rtl/core/qto_front.sv
rtl/core/qto_lane.sv
rtl/core/qto_apply.sv
rtl/core/quaternion_tool_offset_unit.sv
rtl/core/qto_checker.sv
tb/tb_quaternion_tool_offset_unit.sv
